// ===== hdl/sdi_pkg.sv =====
// Shared constants for the segment depth interpolator.
`timescale 1ns / 1ps
package sdi_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int T_FRAC         = 16;
  localparam int T_BITS         = 24;
  localparam int Q_BITS         = 2 * T_BITS;
  localparam int DEPTH_BITS     = 32;
endpackage

// ===== hdl/segment_depth_interpolator.sv =====
// Top level: pipelined depth interpolation along a segment by distance ratio.
// Pipeline: 76 register stages, from the stage 0 squares to the registered output word.
// Throughput: one word per cycle unless the output stalls; the 48-step divider and 24-step square root
// are fully unrolled into one register stage per quotient or root bit.
// The whole pipeline advances together; it holds while the output word waits.
// Reset (rst, synchronous, active high) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module segment_depth_interpolator import sdi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DEPTH_BITS-1:0] depth,
  output logic                         degenerate
);

  // Widths: differences, squares, sums of two squares, root remainder, product, final sum, and shift.
  localparam int DW   = COORD_BITS + 1;
  localparam int SW   = 2 * DW;
  localparam int AW   = SW + 1;
  localparam int RW   = T_BITS + 2;
  localparam int PW   = T_BITS + 1 + DW;
  localparam int SUMW = PW + 2;
  localparam int SH   = T_FRAC - FRAC_BITS;
  // Stage map: squares at stage 0, sums feed the first divider stage, then
  // divider steps, root steps, product, and the registered output word.
  localparam int DIV0 = 1;
  localparam int SQ0  = DIV0 + Q_BITS;
  localparam int MULP = SQ0 + T_BITS;
  localparam int NST  = MULP + 3;

  localparam logic signed [SUMW-1:0] SMAX = SUMW'(64'sh7FFF_FFFF);
  localparam logic signed [SUMW-1:0] SMIN = -SUMW'(64'sh8000_0000);
  localparam logic [T_BITS-1:0]      T_MAX = '1;

  // Sideband that travels with each word.
  logic                  vld [0:NST-1];
  logic signed [DW-1:0]  dz  [0:NST-1];
  logic signed [COORD_BITS-1:0] sz [0:NST-1];
  logic                  dg  [1:NST-1];
  logic                  st  [1:NST-1];

  // One enable moves every stage; a waiting output word stops the line.
  logic en;
  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;

  // Stage 0: squared coordinate differences.
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic [SW-1:0] sqa1, sqa2, sqb1, sqb2;
  assign dax = DW'(point_x) - DW'(start_x);
  assign day = DW'(point_y) - DW'(start_y);
  assign dbx = DW'(end_x) - DW'(start_x);
  assign dby = DW'(end_y) - DW'(start_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa1  <= SW'(dax * dax);
      sqa2  <= SW'(day * day);
      sqb1  <= SW'(dbx * dbx);
      sqb2  <= SW'(dby * dby);
      dz[0] <= DW'(end_z) - DW'(start_z);
      sz[0] <= start_z;
    end
  end

  // Stage 1: squared distances, zero-length and saturated-ratio flags.
  logic [AW-1:0] sum_a, sum_b;
  assign sum_a = AW'(sqa1) + AW'(sqa2);
  assign sum_b = AW'(sqb1) + AW'(sqb2);

  logic [AW-1:0]     drem [0:Q_BITS-1];
  logic [AW-1:0]     dbv  [0:Q_BITS-1];
  logic [T_FRAC-1:0] dlo  [0:Q_BITS-1];
  logic [Q_BITS-1:0] dq   [0:Q_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dg[1]   <= (sum_b == '0);
      st[1]   <= ({{T_FRAC{1'b0}}, sum_a} >= {sum_b, {T_FRAC{1'b0}}});
      drem[0] <= sum_a >> T_FRAC;
      dlo[0]  <= sum_a[T_FRAC-1:0];
      dbv[0]  <= sum_b;
      dq[0]   <= '0;
    end
  end

  genvar p;
  generate
    for (p = 1; p < NST; p++) begin : g_side
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[p] <= 1'b0;
        end else if (en) begin
          vld[p] <= vld[p-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dz[p] <= dz[p-1];
          sz[p] <= sz[p-1];
        end
      end
      if (p > 1) begin : g_flags
        always_ff @(posedge clk) begin
          if (en) begin
            dg[p] <= dg[p-1];
            st[p] <= st[p-1];
          end
        end
      end
    end

    // Restoring divider, one quotient bit per stage: floor(A * 2^32 / B).
    // When the ratio is not saturated, A / 2^16 < B, so 48 bits suffice.
    for (p = 0; p < Q_BITS; p++) begin : g_div
      logic [AW:0] trial;
      logic        ge;
      assign trial = {drem[p], dlo[p][T_FRAC-1]};
      assign ge    = (trial >= {1'b0, dbv[p]});
      always_ff @(posedge clk) begin
        if (en) begin
          dq[p+1] <= {dq[p][Q_BITS-2:0], ge};
        end
      end
      if (p < Q_BITS - 1) begin : g_carry
        logic [AW:0] diff;
        assign diff = trial - {1'b0, dbv[p]};
        always_ff @(posedge clk) begin
          if (en) begin
            drem[p+1] <= ge ? diff[AW-1:0] : trial[AW-1:0];
            dlo[p+1]  <= {dlo[p][T_FRAC-2:0], 1'b0};
            dbv[p+1]  <= dbv[p];
          end
        end
      end
    end
  endgenerate

  // Digit-by-digit integer square root, one root bit per stage.
  logic [Q_BITS-1:0] rq   [0:T_BITS-1];
  logic [RW-1:0]     rrem [0:T_BITS-1];
  logic [T_BITS-1:0] root [0:T_BITS];

  always_comb begin
    rq[0]   = dq[Q_BITS];
    rrem[0] = '0;
    root[0] = '0;
  end

  genvar j;
  generate
    for (j = 0; j < T_BITS; j++) begin : g_sqrt
      logic [RW+1:0] cur, trial;
      logic          ge;
      assign cur   = {rrem[j], rq[j][Q_BITS-1:Q_BITS-2]};
      assign trial = {2'b00, root[j], 2'b01};
      assign ge    = (cur >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          root[j+1] <= {root[j][T_BITS-2:0], ge};
        end
      end
      if (j < T_BITS - 1) begin : g_carry
        logic [RW+1:0] diff;
        assign diff = cur - trial;
        always_ff @(posedge clk) begin
          if (en) begin
            rrem[j+1] <= ge ? diff[RW-1:0] : cur[RW-1:0];
            rq[j+1]   <= {rq[j][Q_BITS-3:0], 2'b00};
          end
        end
      end
    end
  endgenerate

  // Product of the ratio and the depth span.
  logic [T_BITS-1:0]    t_val;
  logic signed [PW-1:0] prod;
  assign t_val = st[MULP] ? T_MAX : root[T_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'($signed({1'b0, t_val}) * dz[MULP]);
    end
  end

  // Final stage: arithmetic shift (floor), add the base depth, saturate.
  logic signed [SUMW-1:0] base, part, total;
  logic signed [DEPTH_BITS-1:0] depth_next;
  always_comb begin
    base  = SUMW'(sz[NST-2]) <<< FRAC_BITS;
    part  = SUMW'(prod) >>> SH;
    total = dg[NST-2] ? base : base + part;
    if (total > SMAX) begin
      depth_next = DEPTH_BITS'(SMAX);
    end else if (total < SMIN) begin
      depth_next = DEPTH_BITS'(SMIN);
    end else begin
      depth_next = DEPTH_BITS'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth <= depth_next;
    end
  end

  // The final stage register is the output word; its flag rides with it.
  assign out_valid  = vld[NST-1];
  assign degenerate = dg[NST-1];

endmodule

// ===== hdl/sdi_checker.sv =====
// Port-level assertions for the segment depth interpolator, with its bind.
`timescale 1ns / 1ps
module sdi_checker import sdi_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DEPTH_BITS-1:0] depth,
  input logic                         degenerate
);

  // A stalled result word keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth) && $stable(degenerate))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  // With no word waiting at the output, the line always moves.
  a_free: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // A waiting output word stalls the input side.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind segment_depth_interpolator sdi_checker u_sdi_checker (.*);
